// ===== rtl/sfsp_pkg.sv =====
// Package: shared types, codes and widths for the SCAN floor stop planner.
package sfsp_pkg;

  localparam int FLOOR_W = 6;   // width of every floor field
  localparam int CNT_W   = 7;   // width of the floor count register
  localparam int IDX_W   = 9;   // width used to compare a cell's fixed index

  localparam logic [CNT_W-1:0] FLOOR_COUNT_RST = 7'd64;

  // Request codes; the unused code behaves as a plain query
  typedef enum logic [1:0] {
    REQ_QUERY = 2'd0,
    REQ_ADD   = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_SPARE = 2'd3
  } req_t;

  // Direction codes; the unused code behaves as no direction
  typedef enum logic [1:0] {
    DIR_HOLD  = 2'd0,
    DIR_UP    = 2'd1,
    DIR_DN    = 2'd2,
    DIR_SPARE = 2'd3
  } dir_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [FLOOR_W-1:0] stop_floor;
    logic [FLOOR_W-1:0] cab_floor;
    logic [1:0]         cab_direction;
  } in_item_t;

  typedef struct packed {
    logic [FLOOR_W-1:0] next_floor;
    logic               next_valid;
    logic               any_pending;
    logic               mark_at_floor;
  } out_item_t;

  // Mark write broadcast to every cell on an accepted transaction
  typedef struct packed {
    logic               en;
    logic               set;
    logic [FLOOR_W-1:0] floor;
  } cell_wr_t;

  // Search context held steady for the whole scan
  typedef struct packed {
    logic [FLOOR_W-1:0] stop_floor;
    logic [FLOOR_W-1:0] cab_floor;
  } scan_ctx_t;

  // Running search result handed from cell to cell
  typedef struct packed {
    logic               any;
    logic               up_ok;
    logic [FLOOR_W-1:0] best_up;
    logic               down_ok;
    logic [FLOOR_W-1:0] best_down;
    logic               sf_hit;
    logic               cab_hit;
  } scan_acc_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_PUSH = 2'd2
  } state_t;

endpackage

// ===== rtl/sfsp_cell.sv =====
// Module: one floor cell, holding its stop mark and passing the scan token on.
module sfsp_cell import sfsp_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [CNT_W-1:0] floor_count,
  input  cell_wr_t         wr,
  input  scan_ctx_t        ctx,
  input  logic             tok_in,
  input  scan_acc_t        acc_in,
  output logic             tok_out,
  output scan_acc_t        acc_out
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic      mark;
  logic      in_use;
  logic      seen;
  logic      above;
  logic      below;
  scan_acc_t acc_next;

  // floor in use when below the configured count
  assign in_use = {{(IDX_W-CNT_W){1'b0}}, floor_count} > MY_IDX;
  assign seen   = mark && in_use;
  assign above  = MY_IDX > {{(IDX_W-FLOOR_W){1'b0}}, ctx.cab_floor};
  assign below  = MY_IDX < {{(IDX_W-FLOOR_W){1'b0}}, ctx.cab_floor};

  // stop mark: add or clear only for a floor in use
  always_ff @(posedge clk) begin
    if (rst) begin
      mark <= 1'b0;
    end else if (wr.en && in_use &&
                 ({{(IDX_W-FLOOR_W){1'b0}}, wr.floor} == MY_IDX)) begin
      mark <= wr.set;
    end
  end

  // fold this floor into the running search
  always_comb begin
    acc_next = acc_in;
    if (seen) begin
      acc_next.any = 1'b1;
      if (above && !acc_in.up_ok) begin
        acc_next.up_ok   = 1'b1;
        acc_next.best_up = MY_IDX[FLOOR_W-1:0];
      end
      if (below) begin
        acc_next.down_ok   = 1'b1;
        acc_next.best_down = MY_IDX[FLOOR_W-1:0];
      end
      if ({{(IDX_W-FLOOR_W){1'b0}}, ctx.stop_floor} == MY_IDX) begin
        acc_next.sf_hit = 1'b1;
      end
      if (!above && !below) begin
        acc_next.cab_hit = 1'b1;
      end
    end
  end

  // token stage
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= 1'b0;
    end else begin
      tok_out <= tok_in;
    end
  end

  // result stage, loaded only as the token passes
  always_ff @(posedge clk) begin
    if (tok_in) begin
      acc_out <= acc_next;
    end
  end

endmodule

// ===== rtl/scan_floor_stop_planner_top.sv =====
// Module: top level of the SCAN floor stop planner, control and result selection.
//
// One stop mark per floor lives in a row of MAX_FLOORS cells. An accepted
// transaction updates the mark at once, then a search token walks the row one
// cell per clock, carrying the nearest stop above and below the cab. The
// result passes from the start register through the cell row and the S_PUSH
// state into the output register, and the next transaction can be accepted
// once the block is back in S_IDLE, so the time each transaction occupies is
// set by the length of the cell row. One transaction is in work at a time; a
// finished result waits in the output register while the next transaction is
// accepted, and a newer result is held back until that register is free. The
// floor count register may be written only while the block is idle.
module scan_floor_stop_planner_top import sfsp_pkg::*; #(
  parameter int MAX_FLOORS = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data
);

  state_t     state;
  state_t     state_next;
  logic [CNT_W-1:0] floor_count;
  logic       start;
  logic       in_fire;
  logic       out_load;
  dir_t       dir;
  scan_ctx_t  ctx;
  cell_wr_t   wr;
  out_item_t  result;
  logic       tok [MAX_FLOORS+1];
  scan_acc_t  acc [MAX_FLOORS+1];
  logic [MAX_FLOORS-1:0] tok_vec;
  scan_acc_t  fin;

  assign in_fire = in_valid && in_ready;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      floor_count <= FLOOR_COUNT_RST;
    end else if (cfg_we) begin
      floor_count <= cfg_wdata;
    end
  end

  // transaction context, held through the scan
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ctx.stop_floor <= in_data.stop_floor;
      ctx.cab_floor  <= in_data.cab_floor;
      dir            <= dir_t'(in_data.cab_direction);
    end
  end

  // mark write goes straight to the cells on acceptance
  always_comb begin
    wr.en    = in_fire && ((req_t'(in_data.req_type) == REQ_ADD) ||
                           (req_t'(in_data.req_type) == REQ_CLEAR));
    wr.set   = req_t'(in_data.req_type) == REQ_ADD;
    wr.floor = in_data.stop_floor;
  end

  // token launches the cycle after acceptance, once marks are updated
  always_ff @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      start <= in_fire;
    end
  end

  assign tok[0] = start;
  assign acc[0] = '0;

  // cell row
  for (genvar i = 0; i < MAX_FLOORS; i++) begin : g_cell
    sfsp_cell #(.IDX(i)) u_cell (
      .clk         (clk),
      .rst         (rst),
      .floor_count (floor_count),
      .wr          (wr),
      .ctx         (ctx),
      .tok_in      (tok[i]),
      .acc_in      (acc[i]),
      .tok_out     (tok[i+1]),
      .acc_out     (acc[i+1])
    );
    assign tok_vec[i] = tok[i+1];
  end

  assign fin = acc[MAX_FLOORS];

  // SCAN choice from the finished search
  always_comb begin
    result.next_floor    = '0;
    result.next_valid    = 1'b0;
    result.any_pending   = fin.any;
    result.mark_at_floor = fin.sf_hit;
    if ((dir == DIR_UP) && fin.up_ok) begin
      result.next_valid = 1'b1;
      result.next_floor = fin.best_up;
    end else if ((dir == DIR_DN) && fin.down_ok) begin
      result.next_valid = 1'b1;
      result.next_floor = fin.best_down;
    end else if ((dir == DIR_UP) && fin.down_ok) begin
      result.next_valid = 1'b1;
      result.next_floor = fin.best_down;
    end else if ((dir == DIR_DN) && fin.up_ok) begin
      result.next_valid = 1'b1;
      result.next_floor = fin.best_up;
    end else if (fin.up_ok && fin.down_ok) begin
      // nearest other floor, lower wins a tie
      result.next_valid = 1'b1;
      if ((fin.best_up - ctx.cab_floor) < (ctx.cab_floor - fin.best_down)) begin
        result.next_floor = fin.best_up;
      end else begin
        result.next_floor = fin.best_down;
      end
    end else if (fin.up_ok) begin
      result.next_valid = 1'b1;
      result.next_floor = fin.best_up;
    end else if (fin.down_ok) begin
      result.next_valid = 1'b1;
      result.next_floor = fin.best_down;
    end else if (fin.cab_hit) begin
      result.next_valid = 1'b1;
      result.next_floor = ctx.cab_floor;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and handshake
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (tok[MAX_FLOORS]) begin
          state_next = S_PUSH;
        end
      end
      S_PUSH: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= result;
    end
  end

`ifndef NO_ASSERTIONS
  // at most one search token in the row
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $countones(tok_vec) <= 1)
    else $error("more than one scan token in the cell row");

  // the token leaves the row only while a scan is running
  a_token_in_scan: assert property (@(posedge clk) disable iff (rst)
    tok[MAX_FLOORS] |-> (state == S_SCAN))
    else $error("scan token finished outside a scan");

  // acceptance launches the token next cycle
  a_launch: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> tok[0])
    else $error("accepted transaction did not launch a scan");

  // a next stop implies some stop is pending
  a_next_needs_pending: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.next_valid) |-> out_data.any_pending)
    else $error("next stop reported with no stop pending");

  // no next stop reads as floor zero
  a_none_is_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.next_valid) |-> (out_data.next_floor == '0))
    else $error("next floor non-zero without a next stop");
`endif

endmodule

// ===== sim/tb_top.sv =====
// Testbench for the SCAN floor stop planner: directed and random stop traffic, self-checked.
`timescale 1ns / 100ps

module tb_top;
  import sfsp_pkg::*;

  localparam int FLOORS = 64;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_wdata;
  logic             in_valid;
  logic             in_ready;
  in_item_t         in_data;
  logic             out_valid;
  logic             out_ready;
  out_item_t        out_data;

  // Shadow copy of the block's state
  bit   [FLOORS-1:0] stop_mark;
  logic [CNT_W-1:0]  floors_set;

  out_item_t report_q[$];   // next-stop reports still owed by the block
  bit        calm;          // 1: no gaps on either side
  int        cab_at;        // cab position for the random walk
  int        n_sent;
  int        n_checked;
  int        n_err;
  int        n_cfg;

  scan_floor_stop_planner_top #(.MAX_FLOORS(FLOORS)) u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the handshake hangs
  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

  // Apply one transaction to the shadow marks and work out the report
  function automatic out_item_t plan_next_stop(input in_item_t it);
    out_item_t res;
    int n;
    int cab;
    int sf;
    int best_up;
    int best_down;
    bit up_ok;
    bit down_ok;
    bit any;
    n         = (floors_set < FLOORS) ? int'(floors_set) : FLOORS;
    cab       = int'(it.cab_floor);
    sf        = int'(it.stop_floor);
    best_up   = 0;
    best_down = 0;
    up_ok     = 1'b0;
    down_ok   = 1'b0;
    any       = 1'b0;
    res       = '0;
    if (sf < n) begin
      if (it.req_type == REQ_ADD) begin
        stop_mark[sf] = 1'b1;
      end else if (it.req_type == REQ_CLEAR) begin
        stop_mark[sf] = 1'b0;
      end
    end
    // nearest mark above the cab is the first one found, nearest below the last
    for (int f = 0; f < n; f++) begin
      if (stop_mark[f]) begin
        any = 1'b1;
        if (f > cab) begin
          if (!up_ok) begin
            up_ok   = 1'b1;
            best_up = f;
          end
        end else if (f < cab) begin
          down_ok   = 1'b1;
          best_down = f;
        end
      end
    end
    res.next_valid = 1'b1;
    if (it.cab_direction == DIR_UP && up_ok) begin
      res.next_floor = FLOOR_W'(best_up);
    end else if (it.cab_direction == DIR_DN && down_ok) begin
      res.next_floor = FLOOR_W'(best_down);
    end else if (it.cab_direction == DIR_UP && down_ok) begin
      res.next_floor = FLOOR_W'(best_down);
    end else if (it.cab_direction == DIR_DN && up_ok) begin
      res.next_floor = FLOOR_W'(best_up);
    end else if (up_ok && down_ok) begin
      // tie goes to the lower floor
      res.next_floor = FLOOR_W'((best_up - cab < cab - best_down) ? best_up : best_down);
    end else if (up_ok || down_ok) begin
      res.next_floor = FLOOR_W'(up_ok ? best_up : best_down);
    end else if (cab < n && stop_mark[cab]) begin
      res.next_floor = FLOOR_W'(cab);
    end else begin
      res.next_valid = 1'b0;
    end
    res.any_pending   = any;
    res.mark_at_floor = (sf < n) && stop_mark[sf];
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Send one transaction; entered and left at a falling edge
  task automatic xmit(input in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  = it;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    report_q.push_back(plan_next_stop(it));
    n_sent++;
    @(negedge clk);
  endtask

  task automatic put(input req_t rq, input int sf, input int cab, input dir_t dir);
    in_item_t it;
    it.req_type      = rq;
    it.stop_floor    = FLOOR_W'(sf);
    it.cab_floor     = FLOOR_W'(cab);
    it.cab_direction = dir;
    xmit(it);
  endtask

  // Write the floor count once the block has drained
  task automatic set_floors(input int unsigned cnt);
    in_valid = 1'b0;
    while (report_q.size() != 0) @(negedge clk);
    @(negedge clk);
    cfg_wdata = cnt[CNT_W-1:0];
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we     = 1'b0;
    floors_set = cnt[CNT_W-1:0];
    n_cfg++;
  endtask

  // Random traffic: mostly a cab walking up and down with calls around it
  task automatic run_phase(input int unsigned cnt, input int items);
    in_item_t it;
    int lim;
    int r;
    set_floors(cnt);
    lim = (cnt == 0) ? 1 : ((cnt > FLOORS) ? FLOORS : cnt);
    if (cab_at >= lim) cab_at = lim - 1;
    for (int k = 0; k < items; k++) begin
      r = $urandom_range(0, 99);
      it.req_type = (r < 40) ? REQ_ADD : (r < 65) ? REQ_CLEAR :
                    (r < 95) ? REQ_QUERY : REQ_SPARE;
      it.stop_floor = FLOOR_W'(($urandom_range(0, 99) < 80) ? $urandom_range(0, lim - 1)
                                                            : $urandom_range(0, FLOORS - 1));
      r = $urandom_range(0, 99);
      if (r < 35) begin
        if (cab_at < lim - 1) cab_at++;
        it.cab_direction = DIR_UP;
      end else if (r < 70) begin
        if (cab_at > 0) cab_at--;
        it.cab_direction = DIR_DN;
      end else if (r < 90) begin
        it.cab_direction = 2'($urandom_range(0, 3));
      end else begin
        cab_at           = $urandom_range(0, FLOORS - 1);
        it.cab_direction = 2'($urandom_range(0, 3));
      end
      it.cab_floor = FLOOR_W'(cab_at);
      xmit(it);
    end
  endtask

  // Extremes, each direction and request code, ties and the floor count corners
  task automatic test_directed();
    set_floors(64);
    put(REQ_QUERY, 0, 0, DIR_HOLD);
    put(REQ_ADD, 63, 0, DIR_UP);
    put(REQ_ADD, 0, 63, DIR_DN);
    put(REQ_QUERY, 63, 32, DIR_HOLD);
    put(REQ_ADD, 31, 32, DIR_HOLD);
    put(REQ_ADD, 33, 32, DIR_HOLD);
    put(REQ_QUERY, 33, 32, DIR_UP);
    put(REQ_QUERY, 31, 32, DIR_DN);
    put(REQ_QUERY, 0, 63, DIR_UP);
    put(REQ_QUERY, 0, 0, DIR_DN);
    put(REQ_SPARE, 5, 32, DIR_SPARE);
    put(REQ_CLEAR, 0, 32, DIR_HOLD);
    put(REQ_CLEAR, 31, 32, DIR_HOLD);
    put(REQ_CLEAR, 33, 32, DIR_HOLD);
    put(REQ_CLEAR, 63, 32, DIR_HOLD);
    put(REQ_ADD, 20, 20, DIR_UP);
    put(REQ_CLEAR, 20, 20, DIR_HOLD);
    // requests and cab outside the floors in use
    set_floors(8);
    put(REQ_ADD, 40, 3, DIR_UP);
    put(REQ_ADD, 7, 50, DIR_DN);
    // a mark hidden by a lower count comes back when it rises
    set_floors(64);
    put(REQ_ADD, 60, 10, DIR_UP);
    set_floors(16);
    put(REQ_QUERY, 60, 10, DIR_UP);
    set_floors(64);
    put(REQ_QUERY, 60, 10, DIR_UP);
    set_floors(0);
    put(REQ_ADD, 0, 0, DIR_HOLD);
    set_floors(127);
    put(REQ_QUERY, 60, 63, DIR_DN);
    set_floors(1);
    put(REQ_ADD, 0, 0, DIR_UP);
  endtask

  // Random traffic over a spread of floor counts, with idling on both sides
  task automatic test_floor_counts();
    calm = 1'b0;
    run_phase(64, 300);
    run_phase(1, 60);
    run_phase(2, 80);
    run_phase($urandom_range(3, 63), 250);
    run_phase($urandom_range(3, 16), 100);
    run_phase(0, 40);
    run_phase(127, 120);
  endtask

  // Full-rate stretch with no gaps and no output stalls, then traffic with both
  task automatic test_back_to_back();
    calm = 1'b1;
    run_phase(64, 150);
    calm = 1'b0;
    run_phase(64, 100);
  endtask

  // Receiver: stretches of ready and stall, mostly short, a few long
  initial begin
    int hold;
    int r;
    hold      = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (calm) begin
        out_ready = 1'b1;
        hold      = 0;
      end else if (hold > 0) begin
        hold--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          out_ready = 1'b1;
          hold      = $urandom_range(0, 8);
        end else if (r < 95) begin
          out_ready = 1'b0;
          hold      = $urandom_range(0, 3);
        end else begin
          out_ready = 1'b0;
          hold      = $urandom_range(20, 40);
        end
      end
    end
  end

  // Check every result transaction against the oldest owed report
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (report_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("tb: result with nothing owed: %p", out_data);
      end else begin
        want = report_q.pop_front();
        n_checked++;
        if (out_data.next_floor !== want.next_floor ||
            out_data.next_valid !== want.next_valid ||
            out_data.any_pending !== want.any_pending ||
            out_data.mark_at_floor !== want.mark_at_floor) begin
          n_err++;
          if (n_err <= 10) begin
            $display("tb: mismatch on report %0d: exp %p, got %p", n_checked, want, out_data);
          end
        end
      end
    end
  end

  // Main sequence
  initial begin
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    in_valid   = 1'b0;
    in_data    = '0;
    stop_mark  = '0;
    floors_set = FLOOR_COUNT_RST;
    calm       = 1'b0;
    cab_at     = 0;
    n_sent     = 0;
    n_checked  = 0;
    n_err      = 0;
    n_cfg      = 0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_floor_counts();
    test_back_to_back();

    in_valid = 1'b0;
    while (report_q.size() != 0) @(posedge clk);
    repeat (FLOORS + 10) @(posedge clk);
    if (report_q.size() != 0) n_err++;

    $display("tb: %0d requests sent, %0d reports checked, %0d floor count writes",
             n_sent, n_checked, n_cfg);
    $display("tb: %0d mismatches", n_err);
    if (n_err == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
